### rtl/ntc_pkg.sv
// Package for the connector over-temperature guard.
// Holds the command, status and config-index codes, the fixed widths and the reset defaults; no dependencies.
package ntc_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int OFFSET_BITS = 8;
    localparam int SKIP_BITS   = 4;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [SKIP_BITS-1:0] SKIP_SAMPLES = SKIP_BITS'(6);

    localparam logic [SAMPLE_BITS-1:0] RST_THR_LOW  = SAMPLE_BITS'(1800);
    localparam logic [SAMPLE_BITS-1:0] RST_THR_MID  = SAMPLE_BITS'(1200);
    localparam logic [SAMPLE_BITS-1:0] RST_THR_HIGH = SAMPLE_BITS'(900);
    localparam logic [OFFSET_BITS-1:0] RST_HYST     = OFFSET_BITS'(5);

    typedef enum logic [1:0] {
        CMD_SAMPLE      = 2'd0,
        CMD_ADAPTER_IN  = 2'd1,
        CMD_ADAPTER_OUT = 2'd2,
        CMD_UNUSED      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_NONE       = 2'd0,
        ST_ON_CLOSED  = 2'd1,
        ST_OFF_OPEN   = 2'd2,
        ST_OFF_CLOSED = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_THR_LOW  = 2'd0,
        CFG_THR_MID  = 2'd1,
        CFG_THR_HIGH = 2'd2,
        CFG_HYST     = 2'd3
    } t_cfg_idx;

endpackage

### rtl/ntc_connector_thermal_protect.sv
// Top level of the connector over-temperature guard.
// Uses ntc_pkg for codes and widths.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one item: a command
//   (NTC sample, adapter inserted, adapter removed), the NTC reading and
//   the adapter detect level. Each accepted item yields exactly one result
//   item on the output channel (o_out_valid / i_out_ready): status, MOSFET
//   drive, protection flag, connector-normal flag and a skipped-sample flag.
//   The result is written into the output register on the edge that
//   accepts the item. Throughput is one item per cycle while the receiver
//   takes each result; all decisions are a few 12-bit compares and one
//   saturating subtract ahead of the guard state and output registers.
//   When the receiver stalls, the result holds and o_in_ready drops only
//   while the output register is full and not being taken.
//   Synchronous reset (i_rst_n low) clears the guard state, the skip counter
//   and the output valid, and restores the threshold registers to defaults.
//   Threshold writes (i_cfg_we) take effect on the next edge; write only
//   while no item is in flight.
module ntc_connector_thermal_protect (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_command,
    input  logic [ntc_pkg::SAMPLE_BITS-1:0]      i_ntc_value,
    input  logic                                 i_adapter_present,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [1:0]                           o_status,
    output logic                                 o_mosfet_open,
    output logic                                 o_protection_latched,
    output logic                                 o_connector_normal,
    output logic                                 o_sample_ignored,
    input  logic                                 i_cfg_we,
    input  logic [ntc_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [ntc_pkg::SAMPLE_BITS-1:0]      i_cfg_data
);
    import ntc_pkg::*;

    // configuration
    logic [SAMPLE_BITS-1:0] r_thr_low, r_thr_mid, r_thr_high;
    logic [OFFSET_BITS-1:0] r_hyst;

    // guard state
    logic                   r_protect, n_protect;
    t_status                r_saved, n_saved;
    t_status                r_live, n_live;
    logic [SKIP_BITS-1:0]   r_skip, n_skip;
    logic                   r_started, n_started;
    logic [SAMPLE_BITS-1:0] r_last, n_last;
    logic                   r_mos, n_mos;

    // output register
    logic                   r_out_valid;
    t_status                r_out_status;
    logic                   r_out_mos, r_out_prot, r_out_normal, r_out_ign;
    logic                   n_ignored, n_normal;

    logic                   accept;
    logic [SAMPLE_BITS-1:0] lowered;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // saturating subtract of the hysteresis offset
    assign lowered = (i_ntc_value > SAMPLE_BITS'(r_hyst))
                   ? i_ntc_value - SAMPLE_BITS'(r_hyst) : '0;

    always_comb begin
        logic [SAMPLE_BITS-1:0] v;
        v         = i_ntc_value;
        n_protect = r_protect;
        n_saved   = r_saved;
        n_live    = r_live;
        n_skip    = r_skip;
        n_started = r_started;
        n_last    = r_last;
        n_mos     = r_mos;
        n_ignored = 1'b0;
        case (i_command)
            CMD_SAMPLE: begin
                n_last = i_ntc_value;
                if (r_skip != '0) begin
                    n_skip    = r_skip - SKIP_BITS'(1);
                    n_ignored = 1'b1;
                end else begin
                    if (i_ntc_value >= r_thr_low) begin
                        n_protect = 1'b0;
                        n_live    = i_adapter_present ? ST_ON_CLOSED : ST_NONE;
                    end else if (i_ntc_value >= r_thr_mid) begin
                        if (r_protect) begin
                            n_live = (r_saved == ST_OFF_CLOSED) ? ST_OFF_CLOSED : ST_OFF_OPEN;
                        end else if (i_adapter_present) begin
                            n_live = ST_ON_CLOSED;
                        end
                    end else begin
                        n_protect = 1'b1;
                        if (r_saved == ST_OFF_CLOSED) begin
                            n_live = ST_OFF_CLOSED;
                        end else begin
                            // already closed: judge the lowered reading and keep it
                            if (r_live == ST_OFF_CLOSED) begin
                                v      = lowered;
                                n_last = lowered;
                            end
                            n_live = (v < r_thr_mid && v >= r_thr_high)
                                   ? ST_OFF_OPEN : ST_OFF_CLOSED;
                        end
                    end
                    n_saved = n_live;
                    // only the two closed statuses pull the drive low
                    n_mos   = !(n_live == ST_OFF_CLOSED || n_live == ST_ON_CLOSED);
                end
            end
            CMD_ADAPTER_IN: begin
                if (!r_started) begin
                    n_skip    = SKIP_SAMPLES;
                    n_started = 1'b1;
                end
            end
            CMD_ADAPTER_OUT: begin
                if (!r_protect && (r_last >= r_thr_low || r_last < r_thr_high)) begin
                    n_protect = 1'b0;
                    n_mos     = 1'b0;
                    n_live    = ST_NONE;
                end
            end
            default: begin
            end
        endcase
        n_normal = !(n_live == ST_OFF_OPEN || n_live == ST_OFF_CLOSED) && !n_protect;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_low  <= RST_THR_LOW;
            r_thr_mid  <= RST_THR_MID;
            r_thr_high <= RST_THR_HIGH;
            r_hyst     <= RST_HYST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_THR_LOW:  r_thr_low  <= i_cfg_data;
                CFG_THR_MID:  r_thr_mid  <= i_cfg_data;
                CFG_THR_HIGH: r_thr_high <= i_cfg_data;
                CFG_HYST:     r_hyst     <= i_cfg_data[OFFSET_BITS-1:0];
                default:      r_hyst     <= r_hyst;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protect   <= 1'b0;
            r_saved     <= ST_NONE;
            r_live      <= ST_NONE;
            r_skip      <= '0;
            r_started   <= 1'b0;
            r_last      <= '0;
            r_mos       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_protect <= n_protect;
                r_saved   <= n_saved;
                r_live    <= n_live;
                r_skip    <= n_skip;
                r_started <= n_started;
                r_last    <= n_last;
                r_mos     <= n_mos;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_status <= n_live;
            r_out_mos    <= n_mos;
            r_out_prot   <= n_protect;
            r_out_normal <= n_normal;
            r_out_ign    <= n_ignored;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_out_status;
    assign o_mosfet_open        = r_out_mos;
    assign o_protection_latched = r_out_prot;
    assign o_connector_normal   = r_out_normal;
    assign o_sample_ignored     = r_out_ign;

`ifndef SYNTHESIS
    // a latched guard always reports a charger-off status
    a_prot_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_protect |-> (r_live == ST_OFF_OPEN || r_live == ST_OFF_CLOSED))
        else $error("protection latched with charger-on status");

    // closed statuses never drive the MOSFET open
    a_closed_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_live == ST_ON_CLOSED || r_live == ST_OFF_CLOSED) |-> !r_mos)
        else $error("closed status with MOSFET open");

    a_open_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_live == ST_OFF_OPEN) |-> r_mos)
        else $error("open status with MOSFET closed");

    // the skip counter is armed to its full count exactly once
    a_skip_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_started) |-> (r_skip == SKIP_SAMPLES))
        else $error("skip counter not armed on first insertion");

    // a reported result mirrors the stored guard state
    a_out_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_status == r_live && o_protection_latched == r_protect
                    && o_mosfet_open == r_mos))
        else $error("result does not match guard state");
`endif

endmodule
